// ----- sv/flow_hash_table_macros.svh -----
// Assertion macros shared by the flow hash table modules.
// Expects i_clk and i_rst_n (synchronous, active low) in the using module.
`ifndef FLOW_HASH_TABLE_MACROS_SVH
`define FLOW_HASH_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fht_pkg.sv -----
// Shared types and constants for the flow hash table.
// Used by fht_ctrl, fht_dp and flow_hash_table; depends on nothing.
package fht_pkg;

    localparam int DEF_NUM_BUCKETS = 256;
    localparam int DEF_BUCKET_WAYS = 4;
    // non power-of-two reduction: reciprocal multiply, multiply back, compare and subtract
    localparam int MOD_STEPS       = 3;
    localparam int MOD_CNT_W       = $clog2(MOD_STEPS);

    // op codes; code 3 behaves as a lookup
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SUM,
        S_MOD,
        S_LEN,
        S_LENW,
        S_READ,
        S_CAP,
        S_CMP,
        S_DEC,
        S_WRITE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic clr;       // clear one chain length entry
        logic load;      // capture the input word
        logic sum;       // finish the key sum
        logic mod_step;  // one step of the bucket reduction
        logic len_rd;    // fetch the chain length, form the base address
        logic rd;        // read one way of the bucket
        logic cmp;       // compare lanes and register the decision
        logic wr;        // write one way of the bucket
        logic fin;       // update chain length, load the result word
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic wr_any;
    } t_stat;

endpackage

// ----- sv/fht_dp.sv -----
// Datapath of the flow hash table: key registers, bucket hash, entry and
// chain length memories, lane registers and compare. Depends on fht_pkg.
`include "flow_hash_table_macros.svh"

module fht_dp #(
    parameter int NUM_BUCKETS = fht_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_WAYS = fht_pkg::DEF_BUCKET_WAYS,
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
    localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fht_pkg::t_cmd     i_cmd,
    input  logic [WW-1:0]     i_idx,
    input  logic [BW-1:0]     i_clr_idx,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_src_addr,
    input  logic [31:0]       i_dst_addr,
    input  logic [15:0]       i_src_port,
    input  logic [15:0]       i_dst_port,
    output fht_pkg::t_stat    o_stat,
    output logic [WW-1:0]     o_rd_hi,
    output logic [WW-1:0]     o_wr_lo,
    output logic [WW-1:0]     o_wr_hi,
    output logic [1:0]        o_status,
    output logic [7:0]        o_bucket,
    output logic [1:0]        o_position
);

    localparam int  LW      = $clog2(BUCKET_WAYS + 1);
    localparam int  DEPTH   = NUM_BUCKETS * BUCKET_WAYS;
    localparam int  AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit  IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
    // floor(2^32 / NUM_BUCKETS); the quotient estimate is at most one low
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_BUCKETS);

    logic [1:0]    r_op;
    logic [31:0]   r_sa, r_da;
    logic [15:0]   r_sp, r_dp;
    logic [31:0]   r_sum;
    logic [16:0]   r_psum;
    logic [31:0]   r_quo;
    logic [BW:0]   r_rraw;
    logic [BW-1:0] r_rem;
    logic [AW-1:0] r_base;
    logic [LW-1:0] r_len;

    logic [63:0]   addr_store [DEPTH];
    logic [31:0]   port_store [DEPTH];
    logic [LW-1:0] len_store  [NUM_BUCKETS];

    logic [63:0]   r_rd_a;
    logic [31:0]   r_rd_p;
    logic          r_cap_pend;
    logic [WW-1:0] r_cap_idx;
    logic [63:0]   r_lane_a [BUCKET_WAYS];
    logic [31:0]   r_lane_p [BUCKET_WAYS];

    logic [1:0]    r_status;
    logic [WW-1:0] r_pos;
    logic          r_chg;
    logic          r_wr_any;
    logic [WW-1:0] r_wr_lo, r_wr_hi;
    logic [LW-1:0] r_new_len;

    logic [1:0]    r_o_status;
    logic [7:0]    r_o_bucket;
    logic [1:0]    r_o_pos;

    logic [63:0]   akey;
    logic [31:0]   pkey;
    logic [63:0]   quo_prod;
    logic [BW:0]   rem_prod, rem_next;
    logic [AW-1:0] mem_addr;
    logic          hit;
    logic [WW-1:0] hit_idx;
    logic          full;
    logic [1:0]    d_status;
    logic [WW-1:0] d_pos, d_lo, d_hi;
    logic          d_chg, d_any;
    logic [LW-1:0] d_len;
    logic [WW-1:0] wsel;
    logic [63:0]   w_a;
    logic [31:0]   w_p;

    assign akey     = {r_sa, r_da};
    assign pkey     = {r_sp, r_dp};
    assign mem_addr = r_base + AW'(i_idx);

    // sum mod NUM_BUCKETS for a non power-of-two count in three steps: reciprocal
    // estimate, multiply back, one compare and subtract; the raw remainder is below 2 * NUM_BUCKETS
    assign quo_prod = 64'(r_sum) * 64'(RECIP);
    assign rem_prod = r_quo[BW:0] * (BW+1)'(NUM_BUCKETS);
    assign rem_next = (r_rraw >= (BW+1)'(NUM_BUCKETS)) ?
                      r_rraw - (BW+1)'(NUM_BUCKETS) : r_rraw;

    // first match, newest first
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = BUCKET_WAYS - 1; j >= 0; j--) begin
            if ((LW'(j) < r_len) && (r_lane_a[j] == akey) && (r_lane_p[j] == pkey)) begin
                hit     = 1'b1;
                hit_idx = WW'(j);
            end
        end
    end

    always_comb begin
        full     = (r_len == LW'(BUCKET_WAYS));
        d_status = fht_pkg::ST_MISS;
        d_pos    = '0;
        d_chg    = 1'b0;
        d_any    = 1'b0;
        d_lo     = '0;
        d_hi     = '0;
        d_len    = r_len;
        case (r_op)
            fht_pkg::OP_INSERT: begin
                if (full) begin
                    d_status = fht_pkg::ST_FULL;
                end else begin
                    d_status = fht_pkg::ST_DONE;
                    d_chg    = 1'b1;
                    d_any    = 1'b1;
                    d_hi     = WW'(r_len);
                    d_len    = r_len + LW'(1);
                end
            end
            fht_pkg::OP_DELETE: begin
                if (hit) begin
                    d_status = fht_pkg::ST_DONE;
                    d_pos    = hit_idx;
                    d_chg    = 1'b1;
                    d_any    = (LW'(hit_idx) + LW'(1)) < r_len;
                    d_lo     = hit_idx;
                    d_hi     = WW'(r_len - LW'(2));
                    d_len    = r_len - LW'(1);
                end
            end
            default: begin
                if (hit) begin
                    d_status = fht_pkg::ST_DONE;
                    d_pos    = hit_idx;
                end
            end
        endcase
    end

    // insert shifts older entries down a rank, delete pulls later ones up
    always_comb begin
        wsel = (r_op == fht_pkg::OP_INSERT) ? WW'(i_idx - 1'b1) : WW'(i_idx + 1'b1);
        if (r_op == fht_pkg::OP_INSERT && i_idx == '0) begin
            w_a = akey;
            w_p = pkey;
        end else begin
            w_a = r_lane_a[wsel];
            w_p = r_lane_p[wsel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_sa   <= i_src_addr;
            r_da   <= i_dst_addr;
            r_sp   <= i_src_port;
            r_dp   <= i_dst_port;
            r_sum  <= i_src_addr + i_dst_addr;
            r_psum <= 17'(i_src_port) + 17'(i_dst_port);
            r_rem  <= '0;
        end
        if (i_cmd.sum) begin
            r_sum <= r_sum + 32'(r_psum);
        end
        if (i_cmd.mod_step) begin
            if (IS_POW2) begin
                r_rem <= BW'(r_sum & 32'(NUM_BUCKETS - 1));
            end else begin
                r_quo  <= quo_prod[63:32];
                r_rraw <= r_sum[BW:0] - rem_prod;
                r_rem  <= BW'(rem_next);
            end
        end
        if (i_cmd.len_rd) begin
            r_base <= AW'(r_rem) * AW'(BUCKET_WAYS);
        end
        if (i_cmd.cmp) begin
            r_status  <= d_status;
            r_pos     <= d_pos;
            r_chg     <= d_chg;
            r_wr_any  <= d_any;
            r_wr_lo   <= d_lo;
            r_wr_hi   <= d_hi;
            r_new_len <= d_len;
        end
        if (i_cmd.fin) begin
            r_o_status <= r_status;
            r_o_bucket <= 8'(r_rem);
            r_o_pos    <= 2'(r_pos);
        end
    end

    // chain length memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            len_store[i_clr_idx] <= '0;
        end else if (i_cmd.fin && r_chg) begin
            len_store[r_rem] <= r_new_len;
        end
        if (i_cmd.len_rd) begin
            r_len <= len_store[r_rem];
        end
    end

    // entry memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            addr_store[mem_addr] <= w_a;
            port_store[mem_addr] <= w_p;
        end
        if (i_cmd.rd) begin
            r_rd_a <= addr_store[mem_addr];
            r_rd_p <= port_store[mem_addr];
        end
    end

    // read data is registered in r_rd_a and r_rd_p, then lands in lane r_cap_idx
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_pend <= 1'b0;
        end else begin
            r_cap_pend <= i_cmd.rd;
        end
        r_cap_idx <= i_idx;
        if (r_cap_pend) begin
            r_lane_a[r_cap_idx] <= r_rd_a;
            r_lane_p[r_cap_idx] <= r_rd_p;
        end
    end

    assign o_stat.len_zero = (r_len == '0);
    assign o_stat.wr_any   = r_wr_any;
    assign o_rd_hi         = WW'(r_len - LW'(1));
    assign o_wr_lo         = r_wr_lo;
    assign o_wr_hi         = r_wr_hi;
    assign o_status        = r_o_status;
    assign o_bucket        = r_o_bucket;
    assign o_position      = r_o_pos;

    `FHT_ASSERT_NOW(a_len_bound, $past(i_cmd.len_rd), r_len <= LW'(BUCKET_WAYS), "chain length above way count")
    `FHT_ASSERT_NOW(a_wr_in_chain, i_cmd.wr, LW'(i_idx) <= r_len, "write beyond chain end")
    `FHT_ASSERT_NOW(a_full_status, i_cmd.fin && r_status == fht_pkg::ST_FULL, r_len == LW'(BUCKET_WAYS), "full status on a bucket with room")

endmodule

// ----- sv/fht_ctrl.sv -----
// Controller of the flow hash table: sequences clear pass, hash, bucket read,
// compare, write back and result handoff. Depends on fht_pkg.
`include "flow_hash_table_macros.svh"

module fht_ctrl #(
    parameter int NUM_BUCKETS = fht_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_WAYS = fht_pkg::DEF_BUCKET_WAYS,
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
    localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  fht_pkg::t_stat i_stat,
    input  logic [WW-1:0]  i_rd_hi,
    input  logic [WW-1:0]  i_wr_lo,
    input  logic [WW-1:0]  i_wr_hi,
    output fht_pkg::t_cmd  o_cmd,
    output logic [WW-1:0]  o_idx,
    output logic [BW-1:0]  o_clr_idx
);

    localparam bit IS_POW2 = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

    fht_pkg::t_state              r_state, n_state;
    logic [WW-1:0]                r_cnt, n_cnt;
    logic [fht_pkg::MOD_CNT_W-1:0] r_bit, n_bit;
    logic [BW-1:0]                r_clr, n_clr;
    logic                         r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fht_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_bit       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            fht_pkg::S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (r_clr == BW'(NUM_BUCKETS - 1)) begin
                    n_state = fht_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            fht_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = fht_pkg::S_SUM;
                end
            end
            fht_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_bit     = '0;
                n_state   = fht_pkg::S_MOD;
            end
            fht_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (IS_POW2 || r_bit == fht_pkg::MOD_CNT_W'(fht_pkg::MOD_STEPS - 1)) begin
                    n_state = fht_pkg::S_LEN;
                end else begin
                    n_bit = r_bit + 1'b1;
                end
            end
            fht_pkg::S_LEN: begin
                o_cmd.len_rd = 1'b1;
                n_state      = fht_pkg::S_LENW;
            end
            fht_pkg::S_LENW: begin
                n_cnt   = '0;
                n_state = i_stat.len_zero ? fht_pkg::S_CMP : fht_pkg::S_READ;
            end
            fht_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                if (r_cnt == i_rd_hi) begin
                    n_state = fht_pkg::S_CAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            fht_pkg::S_CAP: begin
                n_state = fht_pkg::S_CMP;
            end
            fht_pkg::S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = fht_pkg::S_DEC;
            end
            fht_pkg::S_DEC: begin
                n_cnt   = i_wr_lo;
                n_state = i_stat.wr_any ? fht_pkg::S_WRITE : fht_pkg::S_FIN;
            end
            fht_pkg::S_WRITE: begin
                o_cmd.wr = 1'b1;
                if (r_cnt == i_wr_hi) begin
                    n_state = fht_pkg::S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            fht_pkg::S_FIN: begin
                // wait for the result register to drain
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = fht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fht_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != fht_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_idx       = r_cnt;
    assign o_clr_idx   = r_clr;

    `FHT_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == fht_pkg::S_SUM, "accepted word did not start hashing")
    `FHT_ASSERT_NOW(a_fin_free, o_cmd.fin, !r_out_valid || !i_out_stall, "result loaded over a waiting word")
    `FHT_ASSERT_NOW(a_out_rise, $rose(r_out_valid), $past(o_cmd.fin), "result valid without a finished item")

endmodule

// ----- sv/flow_hash_table.sv -----
// Flow table keyed by the four-tuple, NUM_BUCKETS buckets of BUCKET_WAYS
// chained entries, newest first. One item is in flight at a time and each
// gives one result word. After reset a clearing pass over all NUM_BUCKETS
// buckets zeroes the chain lengths; no word is taken meanwhile. Each item
// then runs load, key sum, bucket reduction, chain length fetch, reads of
// the L chain entries, lane capture, compare, write back of W entries and
// result load before the next word is taken. The bucket reduction takes one
// step for a power-of-two bucket count, else three: reciprocal multiply,
// multiply back, compare and subtract. The reads go one entry memory read
// per cycle, and W is L + 1 for an insert into a bucket with room, the
// ranks behind the hit for a delete, else 0. The result word sits in an
// output register, so a new word is accepted while the previous result waits.
// Depends on fht_pkg, fht_ctrl and fht_dp.

module flow_hash_table #(
    parameter int NUM_BUCKETS = fht_pkg::DEF_NUM_BUCKETS,
    parameter int BUCKET_WAYS = fht_pkg::DEF_BUCKET_WAYS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_bucket,
    output logic [1:0]  o_position
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    fht_pkg::t_cmd  cmd;
    fht_pkg::t_stat stat;
    logic [WW-1:0]  idx, rd_hi, wr_lo, wr_hi;
    logic [BW-1:0]  clr_idx;

    fht_ctrl #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .i_rd_hi     (rd_hi),
        .i_wr_lo     (wr_lo),
        .i_wr_hi     (wr_hi),
        .o_cmd       (cmd),
        .o_idx       (idx),
        .o_clr_idx   (clr_idx)
    );

    fht_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .i_clr_idx  (clr_idx),
        .i_op       (i_op),
        .i_src_addr (i_src_addr),
        .i_dst_addr (i_dst_addr),
        .i_src_port (i_src_port),
        .i_dst_port (i_dst_port),
        .o_stat     (stat),
        .o_rd_hi    (rd_hi),
        .o_wr_lo    (wr_lo),
        .o_wr_hi    (wr_hi),
        .o_status   (o_status),
        .o_bucket   (o_bucket),
        .o_position (o_position)
    );

endmodule
